/* hw/rtl/cfcp_pkg.sv */
// ----------------------------------------------------------------------------
// cfcp_pkg: types and constants of the class file constant pool scanner
// Parse phases, result kinds, pool tag codes, the magic word and the
// per-tag body length.
// ----------------------------------------------------------------------------
package cfcp_pkg;

    typedef enum logic [3:0] {
        PH_MAGIC   = 4'd0,
        PH_VERSION = 4'd1,
        PH_COUNT   = 4'd2,
        PH_TAG     = 4'd3,
        PH_BODY    = 4'd4,
        PH_TEXT    = 4'd5,
        PH_ACCESS  = 4'd6,
        PH_THIS    = 4'd7,
        PH_SUPER   = 4'd8,
        PH_DONE    = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        KIND_VERSION   = 3'd0,
        KIND_ENTRY     = 3'd1,
        KIND_TEXT      = 3'd2,
        KIND_UNKNOWN   = 3'd3,
        KIND_ACCESS    = 3'd4,
        KIND_THIS      = 3'd5,
        KIND_SUPER     = 3'd6,
        KIND_BAD_MAGIC = 3'd7
    } t_kind;

    localparam logic [7:0] TAG_UTF8       = 8'd1;
    localparam logic [7:0] TAG_INTEGER    = 8'd3;
    localparam logic [7:0] TAG_FLOAT      = 8'd4;
    localparam logic [7:0] TAG_LONG       = 8'd5;
    localparam logic [7:0] TAG_DOUBLE     = 8'd6;
    localparam logic [7:0] TAG_CLASS      = 8'd7;
    localparam logic [7:0] TAG_STRING     = 8'd8;
    localparam logic [7:0] TAG_FIELDREF   = 8'd9;
    localparam logic [7:0] TAG_METHODREF  = 8'd10;
    localparam logic [7:0] TAG_IMETHODREF = 8'd11;
    localparam logic [7:0] TAG_NAME_TYPE  = 8'd12;

    localparam logic [7:0] MAGIC_0 = 8'hCA;
    localparam logic [7:0] MAGIC_1 = 8'hFE;
    localparam logic [7:0] MAGIC_2 = 8'hBA;
    localparam logic [7:0] MAGIC_3 = 8'hBE;

    localparam logic [7:0] CHAR_MULTI = 8'h58;  // 'X'

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  byte_pos;
        logic [7:0]  field_shift;
        logic [15:0] first_field;
        logic [15:0] slot_number;
        logic [15:0] slots_total;
        logic [7:0]  current_tag;
        logic [15:0] text_remaining;
        logic [1:0]  group_skip;
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] entry_index;
        logic [7:0]  tag_value;
        logic [15:0] value_a;
        logic [15:0] value_b;
        logic [7:0]  text_char;
    } t_result;

    function automatic logic [3:0] body_length(input logic [7:0] tag);
        logic [3:0] len;
        case (tag) inside
            TAG_UTF8, TAG_CLASS, TAG_STRING: len = 4'd2;
            TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF,
            TAG_IMETHODREF, TAG_NAME_TYPE:  len = 4'd4;
            TAG_LONG, TAG_DOUBLE:           len = 4'd8;
            default:                        len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] m;
        unique case (pos)
            2'd0:    m = MAGIC_0;
            2'd1:    m = MAGIC_1;
            2'd2:    m = MAGIC_2;
            default: m = MAGIC_3;
        endcase
        return m;
    endfunction

endpackage

/* hw/rtl/cfcp_step.sv */
// ----------------------------------------------------------------------------
// cfcp_step: one byte of the constant pool parse
// Given the parse state and one input byte, produces the next state and
// at most one result.
// ----------------------------------------------------------------------------
module cfcp_step (
    input  logic [7:0]       i_byte,
    input  logic             i_file_start,
    input  logic             i_check_magic,
    input  cfcp_pkg::t_state i_state,
    output cfcp_pkg::t_state o_state,
    output logic             o_emit,
    output cfcp_pkg::t_result o_result
);

    cfcp_pkg::t_state cur;
    cfcp_pkg::t_state n;
    cfcp_pkg::t_result res;

    logic [15:0] acc;
    logic [2:0]  bp_inc;
    logic [3:0]  need;
    logic [3:0]  tag_need;
    logic        body_done;
    logic [1:0]  ne_step;
    logic [16:0] ne_sum;
    logic        ne_end;
    logic        is_ascii;
    logic        is_two;
    logic        is_three;
    logic [1:0]  used;
    logic [15:0] tr_after;
    logic        emit;

    // file_start clears everything before the byte is used
    always_comb begin
        cur = i_state;
        if (i_file_start) begin
            cur.phase          = i_check_magic ? cfcp_pkg::PH_MAGIC : cfcp_pkg::PH_VERSION;
            cur.byte_pos       = 3'd0;
            cur.field_shift    = 8'd0;
            cur.first_field    = 16'd0;
            cur.slot_number    = 16'd0;
            cur.slots_total    = 16'd0;
            cur.current_tag    = 8'd0;
            cur.text_remaining = 16'd0;
            cur.group_skip     = 2'd0;
        end
    end

    assign acc       = {cur.field_shift, i_byte};
    assign bp_inc    = cur.byte_pos + 3'd1;
    assign need      = cfcp_pkg::body_length(cur.current_tag);
    assign tag_need  = cfcp_pkg::body_length(i_byte);
    // an 8-byte body wraps the 3-bit position to zero
    assign body_done = (bp_inc == 3'd0) || ({1'b0, bp_inc} >= need);

    // long and double take two slots
    assign ne_step = ((cur.phase == cfcp_pkg::PH_BODY) &&
                      ((cur.current_tag == cfcp_pkg::TAG_LONG) ||
                       (cur.current_tag == cfcp_pkg::TAG_DOUBLE))) ? 2'd2 : 2'd1;
    assign ne_sum  = {1'b0, cur.slot_number} + {15'd0, ne_step};
    assign ne_end  = ne_sum >= {1'b0, cur.slots_total};

    assign is_ascii = ~i_byte[7];
    assign is_two   = (i_byte[7:5] == 3'b110);
    assign is_three = (i_byte[7:4] == 4'b1110);
    assign used     = is_two ? 2'd2 : (is_three ? 2'd3 : 2'd1);
    assign tr_after = (cur.text_remaining > {14'd0, used}) ?
                      (cur.text_remaining - {14'd0, used}) : 16'd0;

    // next state
    always_comb begin
        n = cur;
        unique case (cur.phase)
            cfcp_pkg::PH_MAGIC: begin
                if (i_byte != cfcp_pkg::magic_byte(cur.byte_pos[1:0])) begin
                    n.phase = cfcp_pkg::PH_DONE;
                end else if (bp_inc >= 3'd4) begin
                    n.byte_pos = 3'd0;
                    n.phase    = cfcp_pkg::PH_VERSION;
                end else begin
                    n.byte_pos = bp_inc;
                end
            end
            cfcp_pkg::PH_VERSION: begin
                n.field_shift = i_byte;
                n.byte_pos    = bp_inc;
                if (bp_inc == 3'd2) begin
                    n.first_field = acc;
                    n.field_shift = 8'd0;
                end else if (bp_inc >= 3'd4) begin
                    n.byte_pos    = 3'd0;
                    n.field_shift = 8'd0;
                    n.phase       = cfcp_pkg::PH_COUNT;
                end
            end
            cfcp_pkg::PH_COUNT: begin
                n.field_shift = i_byte;
                n.byte_pos    = bp_inc;
                if (bp_inc >= 3'd2) begin
                    n.slots_total = acc;
                    n.byte_pos    = 3'd0;
                    n.field_shift = 8'd0;
                    n.slot_number = 16'd1;
                    n.phase       = (acc <= 16'd1) ? cfcp_pkg::PH_ACCESS : cfcp_pkg::PH_TAG;
                end
            end
            cfcp_pkg::PH_TAG: begin
                n.current_tag = i_byte;
                n.byte_pos    = 3'd0;
                n.field_shift = 8'd0;
                n.first_field = 16'd0;
                if (tag_need == 4'd0) begin
                    n.phase = ne_end ? cfcp_pkg::PH_ACCESS : cfcp_pkg::PH_TAG;
                    if (!ne_end) begin
                        n.slot_number = ne_sum[15:0];
                    end
                end else begin
                    n.phase = cfcp_pkg::PH_BODY;
                end
            end
            cfcp_pkg::PH_BODY: begin
                n.field_shift = i_byte;
                n.byte_pos    = bp_inc;
                if ((bp_inc == 3'd2) && (need == 4'd4)) begin
                    n.first_field = acc;
                end
                if (body_done) begin
                    if ((cur.current_tag == cfcp_pkg::TAG_UTF8) && (acc != 16'd0)) begin
                        // text follows; length is kept for the character results
                        n.first_field    = acc;
                        n.text_remaining = acc;
                        n.group_skip     = 2'd0;
                        n.phase          = cfcp_pkg::PH_TEXT;
                    end else begin
                        if (cur.current_tag == cfcp_pkg::TAG_UTF8) begin
                            n.first_field = acc;
                        end
                        n.byte_pos    = 3'd0;
                        n.field_shift = 8'd0;
                        n.phase = ne_end ? cfcp_pkg::PH_ACCESS : cfcp_pkg::PH_TAG;
                        if (!ne_end) begin
                            n.slot_number = ne_sum[15:0];
                        end
                    end
                end
            end
            cfcp_pkg::PH_TEXT: begin
                if (cur.group_skip != 2'd0) begin
                    n.group_skip = cur.group_skip - 2'd1;
                end else begin
                    n.group_skip     = is_two ? 2'd1 : (is_three ? 2'd2 : 2'd0);
                    n.text_remaining = tr_after;
                end
                if ((n.text_remaining == 16'd0) && (n.group_skip == 2'd0)) begin
                    n.byte_pos    = 3'd0;
                    n.field_shift = 8'd0;
                    n.phase = ne_end ? cfcp_pkg::PH_ACCESS : cfcp_pkg::PH_TAG;
                    if (!ne_end) begin
                        n.slot_number = ne_sum[15:0];
                    end
                end
            end
            cfcp_pkg::PH_ACCESS, cfcp_pkg::PH_THIS, cfcp_pkg::PH_SUPER: begin
                n.field_shift = i_byte;
                n.byte_pos    = bp_inc;
                if (bp_inc >= 3'd2) begin
                    n.byte_pos    = 3'd0;
                    n.field_shift = 8'd0;
                    if (cur.phase == cfcp_pkg::PH_ACCESS) begin
                        n.phase = cfcp_pkg::PH_THIS;
                    end else if (cur.phase == cfcp_pkg::PH_THIS) begin
                        n.phase = cfcp_pkg::PH_SUPER;
                    end else begin
                        n.phase = cfcp_pkg::PH_DONE;
                    end
                end
            end
            default: begin
                n.phase = cfcp_pkg::PH_DONE;
            end
        endcase
    end

    // result
    always_comb begin
        emit            = 1'b0;
        res.kind        = cfcp_pkg::KIND_VERSION;
        res.entry_index = 16'd0;
        res.tag_value   = 8'd0;
        res.value_a     = 16'd0;
        res.value_b     = 16'd0;
        res.text_char   = 8'd0;
        unique case (cur.phase)
            cfcp_pkg::PH_MAGIC: begin
                if (i_byte != cfcp_pkg::magic_byte(cur.byte_pos[1:0])) begin
                    emit     = 1'b1;
                    res.kind = cfcp_pkg::KIND_BAD_MAGIC;
                end
            end
            cfcp_pkg::PH_VERSION: begin
                if (bp_inc >= 3'd4) begin
                    emit        = 1'b1;
                    res.kind    = cfcp_pkg::KIND_VERSION;
                    res.value_a = acc;
                    res.value_b = cur.first_field;
                end
            end
            cfcp_pkg::PH_TAG: begin
                if (tag_need == 4'd0) begin
                    emit            = 1'b1;
                    res.kind        = cfcp_pkg::KIND_UNKNOWN;
                    res.entry_index = cur.slot_number;
                    res.tag_value   = i_byte;
                end
            end
            cfcp_pkg::PH_BODY: begin
                if (body_done) begin
                    emit            = 1'b1;
                    res.kind        = cfcp_pkg::KIND_ENTRY;
                    res.entry_index = cur.slot_number;
                    res.tag_value   = cur.current_tag;
                    case (cur.current_tag) inside
                        cfcp_pkg::TAG_UTF8, cfcp_pkg::TAG_CLASS, cfcp_pkg::TAG_STRING: begin
                            res.value_a = acc;
                        end
                        cfcp_pkg::TAG_FIELDREF, cfcp_pkg::TAG_METHODREF,
                        cfcp_pkg::TAG_IMETHODREF, cfcp_pkg::TAG_NAME_TYPE: begin
                            res.value_a = cur.first_field;
                            res.value_b = acc;
                        end
                        default: begin
                            res.value_a = 16'd0;
                        end
                    endcase
                end
            end
            cfcp_pkg::PH_TEXT: begin
                if ((cur.group_skip == 2'd0) && (is_ascii || is_two || is_three)) begin
                    emit            = 1'b1;
                    res.kind        = cfcp_pkg::KIND_TEXT;
                    res.entry_index = cur.slot_number;
                    res.tag_value   = cfcp_pkg::TAG_UTF8;
                    res.value_a     = cur.first_field;
                    res.text_char   = is_ascii ? i_byte : cfcp_pkg::CHAR_MULTI;
                end
            end
            cfcp_pkg::PH_ACCESS, cfcp_pkg::PH_THIS, cfcp_pkg::PH_SUPER: begin
                if (bp_inc >= 3'd2) begin
                    emit        = 1'b1;
                    res.value_a = acc;
                    if (cur.phase == cfcp_pkg::PH_ACCESS) begin
                        res.kind = cfcp_pkg::KIND_ACCESS;
                    end else if (cur.phase == cfcp_pkg::PH_THIS) begin
                        res.kind = cfcp_pkg::KIND_THIS;
                    end else begin
                        res.kind = cfcp_pkg::KIND_SUPER;
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    assign o_state  = n;
    assign o_emit   = emit;
    assign o_result = res;

endmodule

/* hw/rtl/class_file_constant_pool_scanner_top.sv */
// ----------------------------------------------------------------------------
// class_file_constant_pool_scanner_top: class file constant pool scanner
// Walks a class file byte by byte and reports a bad magic word, version, pool
// entries, unknown tags, text characters of utf8 entries, access flags and the
// class indices.
// Usage:
//   Input channel: i_in_valid / o_in_stall with i_data_byte and i_file_start.
//   A byte is taken on a rising edge with i_in_valid high and o_in_stall low.
//   Raise i_file_start with the first byte of each file to restart the parse.
//   Output channel: o_out_valid / i_out_stall with one result per transaction;
//   a byte gives at most one result, and many bytes give none.
//   Timing: a result is registered and appears in the cycle after its byte.
//   Throughput: one byte per cycle while no held result stalls the input; the
//   result register is refilled on the same edge it is drained.
//   Stall: while a result waits with i_out_stall high, o_in_stall is high and
//   the result holds. A byte that gives no result still needs a free slot.
//   Config: i_cfg_wr_en writes i_cfg_wr_data into check_magic (reset 1); it
//   takes effect at the next file start. Write only while idle.
//   Reset: synchronous, active low; the parse restarts in the magic phase.
// ----------------------------------------------------------------------------
module class_file_constant_pool_scanner_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_file_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [15:0] o_entry_index,
    output logic [7:0]  o_tag_value,
    output logic [15:0] o_value_a,
    output logic [15:0] o_value_b,
    output logic [7:0]  o_text_char,
    output logic        o_last
);

    logic              r_check_magic;
    cfcp_pkg::t_state  r_state;
    cfcp_pkg::t_state  n_state;
    logic              r_out_valid;
    cfcp_pkg::t_result r_result;
    cfcp_pkg::t_result n_result;
    logic              n_emit;
    logic              in_accept;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;

    cfcp_step u_step (
        .i_byte        (i_data_byte),
        .i_file_start  (i_file_start),
        .i_check_magic (r_check_magic),
        .i_state       (r_state),
        .o_state       (n_state),
        .o_emit        (n_emit),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_magic <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_check_magic <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= cfcp_pkg::PH_MAGIC;
            r_state.byte_pos       <= 3'd0;
            r_state.field_shift    <= 8'd0;
            r_state.first_field    <= 16'd0;
            r_state.slot_number    <= 16'd0;
            r_state.slots_total    <= 16'd0;
            r_state.current_tag    <= 8'd0;
            r_state.text_remaining <= 16'd0;
            r_state.group_skip     <= 2'd0;
            r_out_valid            <= 1'b0;
        end else if (in_accept) begin
            r_state     <= n_state;
            r_out_valid <= n_emit;
        end else if (!i_out_stall) begin
            // drop the delivered transaction
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && n_emit) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_result.kind;
    assign o_entry_index = r_result.entry_index;
    assign o_tag_value   = r_result.tag_value;
    assign o_value_a     = r_result.value_a;
    assign o_value_b     = r_result.value_b;
    assign o_text_char   = r_result.text_char;
    assign o_last        = 1'b1;

endmodule

/* hw/rtl/cfcp_checker.sv */
// ----------------------------------------------------------------------------
// cfcp_checker: port-level checks of the constant pool scanner
// Watches the top level's channels and result fields over time.
// ----------------------------------------------------------------------------
module cfcp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_kind,
    input logic [15:0] o_entry_index,
    input logic [7:0]  o_tag_value,
    input logic [15:0] o_value_a,
    input logic [15:0] o_value_b,
    input logic [7:0]  o_text_char,
    input logic        o_last
);

    // a new result only follows an accepted byte
    a_result_from_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid && i_out_stall)) |->
            $past(i_in_valid && !o_in_stall))
        else $error("result appeared without an accepted byte");

    // the input side waits only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with no pending result");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_kind) && $stable(o_value_a) && $stable(o_text_char)))
        else $error("stalled result changed");

    // results outside the pool carry no slot or tag
    a_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == cfcp_pkg::KIND_VERSION || o_kind == cfcp_pkg::KIND_ACCESS ||
                         o_kind == cfcp_pkg::KIND_THIS || o_kind == cfcp_pkg::KIND_SUPER ||
                         o_kind == cfcp_pkg::KIND_BAD_MAGIC)) |->
            (o_entry_index == 16'd0 && o_tag_value == 8'd0 && o_text_char == 8'd0 && o_last))
        else $error("non-pool result carries pool fields");

    // text characters belong to a utf8 entry in a real slot
    a_text_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == cfcp_pkg::KIND_TEXT) |->
            (o_tag_value == cfcp_pkg::TAG_UTF8 && o_entry_index != 16'd0 &&
             o_value_a != 16'd0 && o_value_b == 16'd0))
        else $error("text character outside a utf8 entry");

endmodule

bind class_file_constant_pool_scanner_top cfcp_checker u_cfcp_checker (.*);
